// ===== src/tbef_pkg.sv =====
`timescale 1ns / 1ps

package tbef_pkg;

    localparam int NUM_TIMERS  = 16;
    localparam int QUEUE_DEPTH = 8;

    localparam int TIDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_STOP  = 3'd2;
    localparam logic [2:0] ACT_RESCH = 3'd3;
    localparam logic [2:0] ACT_POP   = 3'd4;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NOT_RUNNING  = 3'd1;
    localparam logic [2:0] ST_EMPTY        = 3'd2;
    localparam logic [2:0] ST_DROPPED      = 3'd3;
    localparam logic [2:0] ST_ZERO_TIMEOUT = 3'd4;

    typedef logic [TIDX_W-1:0] tidx_t;
    typedef logic [QIDX_W-1:0] qidx_t;
    typedef logic [FILL_W-1:0] fill_t;

endpackage

// ===== src/timer_bank_with_event_fifo.sv =====
`timescale 1ns / 1ps

// tick: result strobe once the last timer has been processed, one timer per cycle
// through the shared decrement/expire unit and the timer memory read port.
// start, stop and rejected items: result the cycle after accept, busy stays low.
// reschedule and pop: one memory read, then the S_RESCH or S_POP state registers the result.
// async reset disables all timers and empties the queue; memory contents are
// not cleared. the next item is accepted at the edge ending the result strobe.
module timer_bank_with_event_fifo
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [3:0]  timer_index,
    input  logic        timer_mode,
    input  logic [31:0] timeout_ticks,
    input  logic [31:0] handler_tag,
    input  logic [31:0] param_word,
    output logic        done,
    output logic [2:0]  status,
    output logic        event_valid,
    output logic [31:0] event_handler,
    output logic [31:0] event_param,
    output logic [3:0]  pending_events
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_TICK  = 2'd1;
    localparam logic [1:0] S_RESCH = 2'd2;
    localparam logic [1:0] S_POP   = 2'd3;

    localparam tbef_pkg::tidx_t LAST_TIMER = tbef_pkg::TIDX_W'(tbef_pkg::NUM_TIMERS - 1);
    localparam tbef_pkg::qidx_t LAST_SLOT  = tbef_pkg::QIDX_W'(tbef_pkg::QUEUE_DEPTH - 1);
    localparam tbef_pkg::fill_t FULL_FILL  = tbef_pkg::FILL_W'(tbef_pkg::QUEUE_DEPTH);

    logic [31:0] rem_mem     [tbef_pkg::NUM_TIMERS];
    logic [31:0] reload_mem  [tbef_pkg::NUM_TIMERS];
    logic [31:0] handler_mem [tbef_pkg::NUM_TIMERS];
    logic [31:0] param_mem   [tbef_pkg::NUM_TIMERS];
    logic [31:0] qh_mem      [tbef_pkg::QUEUE_DEPTH];
    logic [31:0] qp_mem      [tbef_pkg::QUEUE_DEPTH];

    logic [1:0]                      state_reg, state_next;
    tbef_pkg::tidx_t                 cnt_reg, cnt_next;
    logic                            issue_reg, issue_next;
    logic                            pvalid_reg, pvalid_next;
    tbef_pkg::tidx_t                 pidx_reg, pidx_next;
    tbef_pkg::tidx_t                 idx_reg, idx_next;
    logic [tbef_pkg::NUM_TIMERS-1:0] enabled_reg, enabled_next;
    logic [tbef_pkg::NUM_TIMERS-1:0] cont_reg, cont_next;
    tbef_pkg::qidx_t                 wr_reg, wr_next;
    tbef_pkg::qidx_t                 rd_reg, rd_next;
    tbef_pkg::fill_t                 fill_reg, fill_next;
    logic                            drop_reg, drop_next;
    logic                            done_reg, done_next;
    logic [2:0]                      status_reg, status_next;
    logic                            evalid_reg, evalid_next;
    logic [31:0]                     eh_reg, eh_next;
    logic [31:0]                     ep_reg, ep_next;
    logic [3:0]                      pending_reg, pending_next;

    logic [31:0] rem_rd_reg, reload_rd_reg, handler_rd_reg, param_rd_reg;
    logic [31:0] qh_rd_reg, qp_rd_reg;

    logic            accept;
    logic            in_range;
    tbef_pkg::tidx_t in_idx;
    tbef_pkg::tidx_t rd_addr;
    logic            start_we;
    logic            rem_we;
    tbef_pkg::tidx_t rem_waddr;
    logic [31:0]     rem_wdata;
    logic            q_we;
    logic [31:0]     dec;
    logic            expire;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign in_range = (32'(timer_index) < 32'(tbef_pkg::NUM_TIMERS));
    assign in_idx   = tbef_pkg::TIDX_W'(timer_index);
    assign rd_addr  = (state_reg == S_TICK) ? cnt_reg : in_idx;
    assign dec      = rem_rd_reg - 32'd1;
    assign expire   = enabled_reg[pidx_reg] && (dec == 32'd0);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        issue_next   = issue_reg;
        pvalid_next  = 1'b0;
        pidx_next    = cnt_reg;
        idx_next     = idx_reg;
        enabled_next = enabled_reg;
        cont_next    = cont_reg;
        wr_next      = wr_reg;
        rd_next      = rd_reg;
        fill_next    = fill_reg;
        drop_next    = drop_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        evalid_next  = 1'b0;
        eh_next      = 32'd0;
        ep_next      = 32'd0;
        start_we     = 1'b0;
        rem_we       = 1'b0;
        rem_waddr    = pidx_reg;
        rem_wdata    = dec;
        q_we         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        tbef_pkg::ACT_TICK:
                        begin
                            state_next = S_TICK;
                            cnt_next   = '0;
                            issue_next = 1'b1;
                            drop_next  = 1'b0;
                        end
                        tbef_pkg::ACT_START:
                        begin
                            done_next = 1'b1;
                            if (!in_range)
                                status_next = tbef_pkg::ST_NOT_RUNNING;
                            else if (timeout_ticks == 32'd0)
                                status_next = tbef_pkg::ST_ZERO_TIMEOUT;
                            else
                            begin
                                status_next          = tbef_pkg::ST_OK;
                                start_we             = 1'b1;
                                enabled_next[in_idx] = 1'b1;
                                cont_next[in_idx]    = timer_mode;
                            end
                        end
                        tbef_pkg::ACT_STOP:
                        begin
                            done_next = 1'b1;
                            if (!in_range)
                                status_next = tbef_pkg::ST_NOT_RUNNING;
                            else
                            begin
                                status_next          = tbef_pkg::ST_OK;
                                enabled_next[in_idx] = 1'b0;
                            end
                        end
                        tbef_pkg::ACT_RESCH:
                        begin
                            if (!in_range || !enabled_reg[in_idx])
                            begin
                                done_next   = 1'b1;
                                status_next = tbef_pkg::ST_NOT_RUNNING;
                            end
                            else
                            begin
                                state_next = S_RESCH;
                                idx_next   = in_idx;
                            end
                        end
                        tbef_pkg::ACT_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = tbef_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_POP;
                                fill_next  = fill_reg - 1'b1;
                                rd_next    = (rd_reg == LAST_SLOT) ? '0 : rd_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = tbef_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_TICK:
            begin
                if (issue_reg)
                begin
                    pvalid_next = 1'b1;
                    pidx_next   = cnt_reg;
                    if (cnt_reg == LAST_TIMER)
                        issue_next = 1'b0;
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
                if (pvalid_reg)
                begin
                    if (enabled_reg[pidx_reg])
                    begin
                        rem_we = 1'b1;
                        if (expire && cont_reg[pidx_reg])
                            rem_wdata = reload_rd_reg;
                    end
                    if (expire)
                    begin
                        if (!cont_reg[pidx_reg])
                            enabled_next[pidx_reg] = 1'b0;
                        if (fill_reg < FULL_FILL)
                        begin
                            q_we      = 1'b1;
                            wr_next   = (wr_reg == LAST_SLOT) ? '0 : wr_reg + 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                        else
                            drop_next = 1'b1;
                    end
                    if (pidx_reg == LAST_TIMER)
                    begin
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                        status_next = drop_next ? tbef_pkg::ST_DROPPED : tbef_pkg::ST_OK;
                    end
                end
            end
            S_RESCH:
            begin
                rem_we      = 1'b1;
                rem_waddr   = idx_reg;
                rem_wdata   = reload_rd_reg;
                state_next  = S_IDLE;
                done_next   = 1'b1;
                status_next = tbef_pkg::ST_OK;
            end
            S_POP:
            begin
                state_next  = S_IDLE;
                done_next   = 1'b1;
                status_next = tbef_pkg::ST_OK;
                evalid_next = 1'b1;
                eh_next     = qh_rd_reg;
                ep_next     = qp_rd_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        pending_next = done_next ? 4'(fill_next) : pending_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            issue_reg   <= 1'b0;
            pvalid_reg  <= 1'b0;
            pidx_reg    <= '0;
            idx_reg     <= '0;
            enabled_reg <= '0;
            cont_reg    <= '0;
            wr_reg      <= '0;
            rd_reg      <= '0;
            fill_reg    <= '0;
            drop_reg    <= 1'b0;
            done_reg    <= 1'b0;
            status_reg  <= tbef_pkg::ST_OK;
            evalid_reg  <= 1'b0;
            pending_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            issue_reg   <= issue_next;
            pvalid_reg  <= pvalid_next;
            pidx_reg    <= pidx_next;
            idx_reg     <= idx_next;
            enabled_reg <= enabled_next;
            cont_reg    <= cont_next;
            wr_reg      <= wr_next;
            rd_reg      <= rd_next;
            fill_reg    <= fill_next;
            drop_reg    <= drop_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            evalid_reg  <= evalid_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eh_reg <= eh_next;
        ep_reg <= ep_next;
    end

    // timer memories
    always_ff @(posedge clk)
    begin
        if (start_we)
        begin
            rem_mem[in_idx]     <= timeout_ticks;
            reload_mem[in_idx]  <= timeout_ticks;
            handler_mem[in_idx] <= handler_tag;
            param_mem[in_idx]   <= param_word;
        end
        else if (rem_we)
            rem_mem[rem_waddr] <= rem_wdata;
        rem_rd_reg     <= rem_mem[rd_addr];
        reload_rd_reg  <= reload_mem[rd_addr];
        handler_rd_reg <= handler_mem[rd_addr];
        param_rd_reg   <= param_mem[rd_addr];
    end

    // event queue memories
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            qh_mem[wr_reg] <= handler_rd_reg;
            qp_mem[wr_reg] <= param_rd_reg;
        end
        qh_rd_reg <= qh_mem[rd_reg];
        qp_rd_reg <= qp_mem[rd_reg];
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign event_valid    = evalid_reg;
    assign event_handler  = eh_reg;
    assign event_param    = ep_reg;
    assign pending_events = pending_reg;

endmodule
